[rtl/core/tach_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tachometer package
// Shared widths, codes, state encoding and the Q16.16 saturation helper.
// ----------------------------------------------------------------------------
package tach_pkg;

  localparam int CAPTURE_BITS = 32;

  localparam int EVENT_W    = 3;
  localparam int CAP_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int NUM_W      = 48;
  localparam int Q_W        = 32;

  localparam int MUL_W      = 32;
  localparam int MUL_CNT_W  = $clog2(MUL_W);
  localparam int DIV_DVD_W  = 64;
  localparam int DIV_DVS_W  = 32;
  localparam int DIV_CNT_W  = $clog2(DIV_DVD_W);

  localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  typedef enum logic [EVENT_W-1:0] {
    EV_TICK     = 3'd0,
    EV_FREQ_CAP = 3'd1,
    EV_DUTY_CAP = 3'd2,
    EV_HALL_B   = 3'd3,
    EV_HALL_C   = 3'd4,
    EV_REVERSAL = 3'd5
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FREQ_NUM  = 3'd0,
    CFG_DUTY_GAIN = 3'd1,
    CFG_DUTY_EXIT = 3'd2,
    CFG_FREQ_EXIT = 3'd3,
    CFG_OUT_GAIN  = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_DIV,
    ST_RPM,
    ST_MUL_B,
    ST_FIN
  } state_t;

  // Signed value from magnitude and sign, clipped to the Q16.16 range
  function automatic logic signed [Q_W-1:0] sat_q16(input logic [63:0] mag, input logic neg);
    logic big;
    logic [Q_W-1:0] low;
    big = |mag[63:Q_W-1];
    low = mag[Q_W-1:0];
    if (neg) begin
      sat_q16 = big ? Q_MIN : -$signed(low);
    end else begin
      sat_q16 = big ? Q_MAX : $signed(low);
    end
  endfunction

endpackage
`default_nettype wire

[rtl/core/dual_mode_tachometer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dual-mode tachometer
// Period/duty speed measurement with hall direction sign, mode hysteresis,
// output scaling and saturation. One beat per event, one result per tick.
// ----------------------------------------------------------------------------
// Non-tick events are accepted while idle and give no result.
// Tick: duty mode runs the 32-step shift-add multiplier, the 64-step divider
// and the multiplier again; frequency mode the divider, then the multiplier;
// a missing capture only the multiplier. One event is in flight at a time;
// a finished result waits in the output register while the next event is
// taken. Synchronous reset clears control state and loads config defaults.
module dual_mode_tachometer import tach_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [EVENT_W-1:0]    in_event_kind,
  input  logic [CAP_W-1:0]      in_period_capture,
  input  logic [CAP_W-1:0]      in_low_capture,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [Q_W-1:0] out_speed_out,
  output logic                  out_mode_after,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // configuration
  logic [NUM_W-1:0]        freq_num_r;
  logic [Q_W-1:0]          duty_gain_r;
  logic signed [Q_W-1:0]   duty_exit_r;
  logic signed [Q_W-1:0]   freq_exit_r;
  logic [Q_W-1:0]          out_gain_r;

  // state and next
  state_t                  state_r, state_nxt;
  logic [CAPTURE_BITS-1:0] freq_period_r, freq_period_nxt;
  logic [CAPTURE_BITS-1:0] duty_low_r, duty_low_nxt;
  logic [CAPTURE_BITS-1:0] duty_period_r, duty_period_nxt;
  logic                    mode_r, mode_nxt;
  logic                    seen_a_r, seen_a_nxt;
  logic                    seen_b_r, seen_b_nxt;
  logic                    neg_dir_r, neg_dir_nxt;
  logic [DIV_DVS_W-1:0]    divisor_r, divisor_nxt;
  logic                    neg_r, neg_nxt;
  logic                    have_r, have_nxt;
  logic signed [Q_W-1:0]   rpm_r, rpm_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [Q_W-1:0]   speed_r, speed_nxt;
  logic                    mode_out_r, mode_out_nxt;

  // arithmetic units
  logic                    mul_start;
  logic [MUL_W-1:0]        mul_a;
  logic [MUL_W-1:0]        mul_b;
  logic                    mul_done;
  logic [2*MUL_W-1:0]      mul_product;
  logic                    div_start;
  logic [DIV_DVD_W-1:0]    div_dividend;
  logic [DIV_DVS_W-1:0]    div_divisor;
  logic                    div_done;
  logic [DIV_DVD_W-1:0]    div_quot;

  event_t                  ev;
  logic                    in_acc;
  logic [CAP_W-1:0]        low_ext;
  logic [CAP_W-1:0]        per_ext;
  logic                    below;
  logic signed [Q_W-1:0]   rpm_calc;
  logic [Q_W-1:0]          rpm_abs;

  tach_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_product)
  );

  tach_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_num_r  <= '0;
      duty_gain_r <= 32'd6553600;
      duty_exit_r <= '0;
      freq_exit_r <= '0;
      out_gain_r  <= 32'd6863;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FREQ_NUM:  freq_num_r  <= cfg_wdata[NUM_W-1:0];
        CFG_DUTY_GAIN: duty_gain_r <= cfg_wdata[Q_W-1:0];
        CFG_DUTY_EXIT: duty_exit_r <= $signed(cfg_wdata[Q_W-1:0]);
        CFG_FREQ_EXIT: freq_exit_r <= $signed(cfg_wdata[Q_W-1:0]);
        CFG_OUT_GAIN:  out_gain_r  <= cfg_wdata[Q_W-1:0];
        default: ;
      endcase
    end
  end

  assign ev       = event_t'(in_event_kind);
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign low_ext  = CAP_W'(duty_low_r);
  assign per_ext  = CAP_W'(duty_period_r);
  assign below    = low_ext > per_ext;
  assign rpm_calc = have_r ? sat_q16(div_quot, neg_r) : '0;
  assign rpm_abs  = rpm_calc[Q_W-1] ? Q_W'(-rpm_calc) : Q_W'(rpm_calc);

  always_comb begin
    state_nxt       = state_r;
    freq_period_nxt = freq_period_r;
    duty_low_nxt    = duty_low_r;
    duty_period_nxt = duty_period_r;
    mode_nxt        = mode_r;
    seen_a_nxt      = seen_a_r;
    seen_b_nxt      = seen_b_r;
    neg_dir_nxt     = neg_dir_r;
    divisor_nxt     = divisor_r;
    neg_nxt         = neg_r;
    have_nxt        = have_r;
    rpm_nxt         = rpm_r;
    out_valid_nxt   = out_valid_r && out_stall;
    speed_nxt       = speed_r;
    mode_out_nxt    = mode_out_r;
    mul_start       = 1'b0;
    mul_a           = '0;
    mul_b           = '0;
    div_start       = 1'b0;
    div_dividend    = '0;
    div_divisor     = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (ev)
            EV_FREQ_CAP: begin
              freq_period_nxt = in_period_capture[CAPTURE_BITS-1:0];
              seen_a_nxt      = 1'b1;
              if (seen_b_r) begin
                neg_dir_nxt = 1'b0;
              end
            end
            EV_DUTY_CAP: begin
              duty_period_nxt = in_period_capture[CAPTURE_BITS-1:0];
              duty_low_nxt    = in_low_capture[CAPTURE_BITS-1:0];
            end
            EV_HALL_B: begin
              seen_b_nxt = 1'b1;
              if (seen_a_r) begin
                neg_dir_nxt = 1'b1;
              end
            end
            EV_HALL_C, EV_REVERSAL: begin
              seen_a_nxt = 1'b0;
              seen_b_nxt = 1'b0;
            end
            EV_TICK: begin
              if (!mode_r) begin
                if (duty_period_r != '0 && duty_low_r != '0) begin
                  mul_start       = 1'b1;
                  mul_a           = below ? (low_ext - per_ext) : (per_ext - low_ext);
                  mul_b           = duty_gain_r;
                  divisor_nxt     = per_ext;
                  neg_nxt         = below ^ neg_dir_r;
                  have_nxt        = 1'b1;
                  duty_low_nxt    = '0;
                  duty_period_nxt = '0;
                  state_nxt       = ST_MUL_A;
                end else begin
                  have_nxt  = 1'b0;
                  state_nxt = ST_RPM;
                end
              end else begin
                if (freq_period_r != '0) begin
                  div_start       = 1'b1;
                  div_dividend    = DIV_DVD_W'(freq_num_r);
                  div_divisor     = DIV_DVS_W'(freq_period_r);
                  neg_nxt         = neg_dir_r;
                  have_nxt        = 1'b1;
                  freq_period_nxt = '0;
                  state_nxt       = ST_DIV;
                end else begin
                  have_nxt  = 1'b0;
                  state_nxt = ST_RPM;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_MUL_A: begin
        if (mul_done) begin
          div_start    = 1'b1;
          div_dividend = mul_product;
          div_divisor  = divisor_r;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_RPM;
        end
      end
      ST_RPM: begin
        rpm_nxt = rpm_calc;
        if (!mode_r) begin
          if (rpm_calc > duty_exit_r) begin
            mode_nxt = 1'b1;
          end
        end else begin
          if (rpm_calc < freq_exit_r) begin
            mode_nxt = 1'b0;
          end
        end
        mul_start = 1'b1;
        mul_a     = rpm_abs;
        mul_b     = out_gain_r;
        state_nxt = ST_MUL_B;
      end
      ST_MUL_B: begin
        if (mul_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          speed_nxt     = sat_q16({16'd0, mul_product[2*MUL_W-1:16]}, rpm_r[Q_W-1]);
          mode_out_nxt  = mode_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      freq_period_r <= '0;
      duty_low_r    <= '0;
      duty_period_r <= '0;
      mode_r        <= 1'b0;
      seen_a_r      <= 1'b0;
      seen_b_r      <= 1'b0;
      neg_dir_r     <= 1'b0;
      have_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      freq_period_r <= freq_period_nxt;
      duty_low_r    <= duty_low_nxt;
      duty_period_r <= duty_period_nxt;
      mode_r        <= mode_nxt;
      seen_a_r      <= seen_a_nxt;
      seen_b_r      <= seen_b_nxt;
      neg_dir_r     <= neg_dir_nxt;
      have_r        <= have_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    divisor_r  <= divisor_nxt;
    neg_r      <= neg_nxt;
    rpm_r      <= rpm_nxt;
    speed_r    <= speed_nxt;
    mode_out_r <= mode_out_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_speed_out  = speed_r;
  assign out_mode_after = mode_out_r;

  // a new beat only appears on leaving the final state
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result beat raised outside final state");

  // the final state always hands its result over once the slot is free
  a_fin_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && state_r == ST_FIN && !(out_valid_r && out_stall)) |=> out_valid_r)
    else $error("result lost in final state");

  // mode only moves on the decision step
  a_mode_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(mode_r)) |-> $past(state_r == ST_RPM))
    else $error("mode changed outside decision step");

  // a duty tick leaves no complete duty capture behind
  a_duty_consumed: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && in_acc && ev == EV_TICK && !mode_r)
      |=> (duty_period_r == '0 || duty_low_r == '0))
    else $error("duty capture not consumed");

  // multiplier results only come back while waiting for them
  a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == ST_MUL_A || state_r == ST_MUL_B))
    else $error("unexpected multiplier completion");

endmodule
`default_nettype wire

[rtl/core/tach_mul.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tachometer serial multiplier
// Shift-add multiplier, one multiplier bit per cycle, 2*MUL_W bit product.
// ----------------------------------------------------------------------------
module tach_mul import tach_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [MUL_W-1:0]     a,
  input  logic [MUL_W-1:0]     b,
  output logic                 done,
  output logic [2*MUL_W-1:0]   product
);

  logic [MUL_W-1:0]     a_r;
  logic [MUL_W-1:0]     hi_r;
  logic [MUL_W-1:0]     lo_r;
  logic [MUL_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [MUL_W:0]       sum;

  assign sum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, a_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r    <= a;
        hi_r   <= '0;
        lo_r   <= b;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        hi_r  <= sum[MUL_W:1];
        lo_r  <= {sum[0], lo_r[MUL_W-1:1]};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == MUL_CNT_W'(MUL_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done    = done_r;
  assign product = {hi_r, lo_r};

endmodule
`default_nettype wire

[rtl/core/tach_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tachometer serial divider
// Restoring divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module tach_div import tach_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_DVD_W-1:0] dividend,
  input  logic [DIV_DVS_W-1:0] divisor,
  output logic                 done,
  output logic [DIV_DVD_W-1:0] quotient
);

  logic [DIV_DVD_W-1:0] quo_r;
  logic [DIV_DVS_W-1:0] rem_r;
  logic [DIV_DVS_W-1:0] dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DIV_DVS_W:0]   shifted;
  logic [DIV_DVS_W+1:0] trial;
  logic                 fits;

  assign shifted = {rem_r, quo_r[DIV_DVD_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs_r};
  assign fits    = !trial[DIV_DVS_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r  <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= fits ? trial[DIV_DVS_W-1:0] : shifted[DIV_DVS_W-1:0];
        quo_r <= {quo_r[DIV_DVD_W-2:0], fits};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire
